>>> sv/imu_tilt_complementary_filter_top_assert.svh
// assertion macros for the tilt filter top level
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITCF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itcf check failed");
`define ITCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itcf check failed");
`else
`define ITCF_ASSERT_SAME(label, ante, cons)
`define ITCF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/itcf_pkg.sv
// shared types, constants and the arctangent table of the tilt filter
package itcf_pkg;

  localparam int CW      = 26;  // cordic x/y width
  localparam int ZW      = 25;  // cordic angle accumulator width
  localparam int AW      = 23;  // clamped accel angle, degrees * 2^16
  localparam int NUM_W   = 60;  // blend numerator width
  localparam int QW      = 18;  // quotient magnitude width
  localparam int DTW     = 10;  // elapsed time width

  localparam logic [AW-1:0]    DEG90_Q16    = 23'd5898240;
  localparam logic [17:0]      GYRO_SCALE   = 18'd131000;
  localparam logic [NUM_W-1:0] DEN          = 60'd2197815296000;
  localparam logic [NUM_W-1:0] DEN_HALF     = 60'd1098907648000;
  localparam logic [NUM_W-1:0] DEN_TOP      = DEN << (QW - 1);
  localparam logic [QW-1:0]    Q_POS_LIM    = 18'd32767;
  localparam logic [QW-1:0]    Q_NEG_LIM    = 18'd32768;
  localparam logic [15:0]      ANGLE_MAX    = 16'h7fff;
  localparam logic [15:0]      ANGLE_MIN    = 16'h8000;
  localparam logic [DTW-1:0]   DT_DEFAULT   = 10'd10;
  localparam logic [31:0]      DT_LIMIT     = 32'd1000;

  localparam logic [2:0] REG_BLEND_WEIGHT   = 3'd0;
  localparam logic [2:0] REG_ASP_LOW        = 3'd1;
  localparam logic [2:0] REG_ASP_HIGH       = 3'd2;
  localparam logic [2:0] REG_DISP_LOW       = 3'd3;
  localparam logic [2:0] REG_DISP_HIGH      = 3'd4;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] angle;
  } cordic_rsp_t;

  typedef struct packed {
    logic                start;
    logic [AW-1:0]       angle;
    logic signed [15:0]  filt;
    logic signed [15:0]  gyro;
    logic [DTW-1:0]      dt;
    logic [15:0]         weight;
  } blend_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] angle;
  } blend_rsp_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [AW-1:0] atan_q16(input logic [4:0] i);
    logic [AW-1:0] t;
    unique case (i)
      5'd0:  t = 23'd2949120;
      5'd1:  t = 23'd1740967;
      5'd2:  t = 23'd919879;
      5'd3:  t = 23'd466945;
      5'd4:  t = 23'd234379;
      5'd5:  t = 23'd117304;
      5'd6:  t = 23'd58666;
      5'd7:  t = 23'd29335;
      5'd8:  t = 23'd14668;
      5'd9:  t = 23'd7334;
      5'd10: t = 23'd3667;
      5'd11: t = 23'd1833;
      5'd12: t = 23'd917;
      5'd13: t = 23'd458;
      5'd14: t = 23'd229;
      5'd15: t = 23'd115;
      5'd16: t = 23'd57;
      5'd17: t = 23'd29;
      5'd18: t = 23'd14;
      5'd19: t = 23'd7;
      5'd20: t = 23'd4;
      5'd21: t = 23'd2;
      5'd22: t = 23'd1;
      default: t = 23'd0;
    endcase
    return t;
  endfunction

endpackage

>>> sv/itcf_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle
module itcf_cordic #(
  parameter int STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itcf_pkg::cordic_req_t req,
  output itcf_pkg::cordic_rsp_t rsp
);

  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t                        state_r;
  logic [STEP_W-1:0]              step_r;
  logic signed [itcf_pkg::CW-1:0] x_r, y_r;
  logic signed [itcf_pkg::ZW-1:0] z_r;
  logic                           done_r;
  logic [itcf_pkg::AW-1:0]        angle_r;

  logic signed [itcf_pkg::CW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [itcf_pkg::ZW-1:0] z_nxt, t_ext;
  logic [itcf_pkg::AW-1:0]        angle_nxt;

  always_comb begin
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    t_ext = $signed({2'b00, itcf_pkg::atan_q16(5'(step_r))});
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + t_ext;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - t_ext;
    end
    // clamp to the first quadrant
    if (z_nxt[itcf_pkg::ZW-1]) begin
      angle_nxt = '0;
    end else if (z_nxt > $signed({2'b00, itcf_pkg::DEG90_Q16})) begin
      angle_nxt = itcf_pkg::DEG90_Q16;
    end else begin
      angle_nxt = z_nxt[itcf_pkg::AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (req.start) begin
            x_r     <= req.x;
            y_r     <= req.y;
            z_r     <= '0;
            step_r  <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(STEPS - 1)) begin
            angle_r <= angle_nxt;
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = angle_r;

endmodule

>>> sv/itcf_blend.sv
// blend datapath: serial shift-add multiply, restoring divide, saturation
module itcf_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itcf_pkg::blend_req_t req,
  output itcf_pkg::blend_rsp_t rsp
);

  localparam int NW = itcf_pkg::NUM_W;

  typedef enum logic [2:0] {B_IDLE, B_PRE1, B_PRE2, B_PRE3, B_MUL, B_ABS, B_DIV, B_SAT}
    bstate_t;

  bstate_t                   state_r;
  logic [4:0]                cnt_r;
  logic [itcf_pkg::AW-1:0]   a_r;
  logic signed [15:0]        f_r, g_r;
  logic [itcf_pkg::DTW-1:0]  dt_r;
  logic [15:0]               w_r;
  logic signed [34:0]        fm_r;
  logic signed [26:0]        gd_r;
  logic [40:0]               qa_r;
  logic signed [NW-1:0]      d_r, acc_r;
  logic [NW-1:0]             rem_r, dsh_r;
  logic [itcf_pkg::QW-1:0]   q_r;
  logic                      neg_r;
  logic                      done_r;
  logic [15:0]               res_r;

  logic signed [34:0]        fm_nxt;
  logic signed [26:0]        gd_nxt;
  logic [40:0]               qa_nxt;
  logic signed [NW-1:0]      d_nxt, mag_s;
  logic [15:0]               res_nxt;
  logic                      fit;

  always_comb begin
    fm_nxt = f_r * $signed({1'b0, itcf_pkg::GYRO_SCALE});
    gd_nxt = g_r * $signed({1'b0, dt_r});
    qa_nxt = a_r * itcf_pkg::GYRO_SCALE;
    // gyro path minus accel path, so num = accel<<16 + w*d
    d_nxt  = {{(NW-43){fm_r[34]}}, fm_r, 8'b0}
           + {{(NW-43){gd_r[26]}}, gd_r, 16'b0}
           - $signed({{(NW-41){1'b0}}, qa_r});
    mag_s  = acc_r[NW-1] ? -acc_r : acc_r;
    fit    = rem_r >= dsh_r;
    if (neg_r) begin
      res_nxt = (q_r > itcf_pkg::Q_NEG_LIM) ? itcf_pkg::ANGLE_MIN : 16'(-q_r[15:0]);
    end else begin
      res_nxt = (q_r > itcf_pkg::Q_POS_LIM) ? itcf_pkg::ANGLE_MAX : q_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (req.start) begin
            a_r     <= req.angle;
            f_r     <= req.filt;
            g_r     <= req.gyro;
            dt_r    <= req.dt;
            w_r     <= req.weight;
            state_r <= B_PRE1;
          end
        end
        B_PRE1: begin
          fm_r    <= fm_nxt;
          gd_r    <= gd_nxt;
          state_r <= B_PRE2;
        end
        B_PRE2: begin
          qa_r    <= qa_nxt;
          state_r <= B_PRE3;
        end
        B_PRE3: begin
          d_r     <= d_nxt;
          acc_r   <= $signed({3'b000, qa_r, 16'b0});
          cnt_r   <= '0;
          state_r <= B_MUL;
        end
        B_MUL: begin
          // one weight bit per cycle, lsb first
          if (w_r[0]) begin
            acc_r <= acc_r + d_r;
          end
          d_r   <= d_r <<< 1;
          w_r   <= w_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd15) begin
            state_r <= B_ABS;
          end
        end
        B_ABS: begin
          neg_r   <= acc_r[NW-1];
          rem_r   <= mag_s + itcf_pkg::DEN_HALF;
          dsh_r   <= itcf_pkg::DEN_TOP;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          // one quotient bit per cycle, msb first
          if (fit) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[itcf_pkg::QW-2:0], fit};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(itcf_pkg::QW - 1)) begin
            state_r <= B_SAT;
          end
        end
        B_SAT: begin
          res_r   <= res_nxt;
          done_r  <= 1'b1;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = res_r;

endmodule

>>> sv/imu_tilt_complementary_filter_top.sv
// Tilt-angle complementary filter. One result per accepted sample. The CORDIC loop
// loads its operands and then runs one micro-rotation a cycle. The blend unit then
// loads its operands, runs its set-up states, does the multiply at one weight bit a
// cycle, takes the magnitude, does the rounding division by the scale factor at one
// quotient bit a cycle and saturates. The result is then handed to the output
// register and the control returns to idle. Input is accepted only while no item is
// in work. A finished result waits in the output register, so the next sample can be
// taken before it is collected; a second result then holds the input until the first
// is taken. No clearing pass follows reset.
`include "imu_tilt_complementary_filter_top_assert.svh"

module imu_tilt_complementary_filter_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // accel_x, accel_z, gyro_y, time_ms
  input  logic [1:0]  in_tuser,   // aspirate_pressed, dispense_pressed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // tilt_angle
  output logic [1:0]  out_tuser,  // angle_ok, current_mode
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_CRD, ST_BLD, ST_OUT} state_t;

  state_t                     state_r;
  logic [15:0]                weight_r, asp_lo_r, asp_hi_r, disp_lo_r, disp_hi_r;
  logic signed [15:0]         filt_r, g_r;
  logic [31:0]                prev_r;
  logic                       mode_r;
  logic [itcf_pkg::DTW-1:0]   dt_r;
  logic                       crd_start_r, bld_start_r;
  logic signed [itcf_pkg::CW-1:0] x_r, y_r;
  logic [itcf_pkg::AW-1:0]    angle_r;
  logic [15:0]                res_r;
  logic                       out_valid_r;
  logic [15:0]                out_angle_r;
  logic                       out_ok_r, out_mode_r;

  itcf_pkg::cordic_req_t crd_req;
  itcf_pkg::cordic_rsp_t crd_rsp;
  itcf_pkg::blend_req_t  bld_req;
  itcf_pkg::blend_rsp_t  bld_rsp;

  logic              in_acc, cfg_wr, out_load, ok;
  logic [2:0]        cfg_idx;
  logic [31:0]       elapsed;
  logic [itcf_pkg::DTW-1:0] dt_nxt;
  logic [16:0]       ax_abs, az_abs;
  logic signed [15:0] ax, az, lo, hi;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    ax      = $signed(in_tdata[15:0]);
    az      = $signed(in_tdata[31:16]);
    ax_abs  = ax[15] ? 17'(-$signed({ax[15], ax})) : {1'b0, ax};
    az_abs  = az[15] ? 17'(-$signed({az[15], az})) : {1'b0, az};
    elapsed = in_tdata[79:48] - prev_r;
    dt_nxt  = (elapsed == '0 || elapsed > itcf_pkg::DT_LIMIT) ? itcf_pkg::DT_DEFAULT
                                                               : elapsed[itcf_pkg::DTW-1:0];
    lo      = $signed(mode_r ? disp_lo_r : asp_lo_r);
    hi      = $signed(mode_r ? disp_hi_r : asp_hi_r);
    ok      = ($signed(res_r) >= lo) && ($signed(res_r) <= hi);
    unique case (cfg_idx)
      itcf_pkg::REG_BLEND_WEIGHT: cfg_prdata = {16'b0, weight_r};
      itcf_pkg::REG_ASP_LOW:      cfg_prdata = {{16{asp_lo_r[15]}}, asp_lo_r};
      itcf_pkg::REG_ASP_HIGH:     cfg_prdata = {{16{asp_hi_r[15]}}, asp_hi_r};
      itcf_pkg::REG_DISP_LOW:     cfg_prdata = {{16{disp_lo_r[15]}}, disp_lo_r};
      itcf_pkg::REG_DISP_HIGH:    cfg_prdata = {{16{disp_hi_r[15]}}, disp_hi_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= 16'd64225;
      asp_lo_r  <= 16'd21760;
      asp_hi_r  <= 16'd24320;
      disp_lo_r <= 16'd7680;
      disp_hi_r <= 16'd15360;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        itcf_pkg::REG_BLEND_WEIGHT: weight_r  <= cfg_pwdata[15:0];
        itcf_pkg::REG_ASP_LOW:      asp_lo_r  <= cfg_pwdata[15:0];
        itcf_pkg::REG_ASP_HIGH:     asp_hi_r  <= cfg_pwdata[15:0];
        itcf_pkg::REG_DISP_LOW:     disp_lo_r <= cfg_pwdata[15:0];
        itcf_pkg::REG_DISP_HIGH:    disp_hi_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filt_r      <= '0;
      prev_r      <= '0;
      mode_r      <= 1'b0;
      crd_start_r <= 1'b0;
      bld_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crd_start_r <= 1'b0;
      bld_start_r <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_angle_r <= res_r;
        out_ok_r    <= ok;
        out_mode_r  <= mode_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // dispense wins when both buttons are down
            if (in_tuser[1]) begin
              mode_r <= 1'b1;
            end else if (in_tuser[0]) begin
              mode_r <= 1'b0;
            end
            prev_r      <= in_tdata[79:48];
            dt_r        <= dt_nxt;
            g_r         <= $signed(in_tdata[47:32]);
            x_r         <= $signed({1'b0, ax_abs, 8'b0});
            y_r         <= $signed({1'b0, az_abs, 8'b0});
            crd_start_r <= 1'b1;
            state_r     <= ST_CRD;
          end
        end
        ST_CRD: begin
          if (crd_rsp.done) begin
            angle_r     <= crd_rsp.angle;
            bld_start_r <= 1'b1;
            state_r     <= ST_BLD;
          end
        end
        ST_BLD: begin
          if (bld_rsp.done) begin
            res_r   <= bld_rsp.angle;
            filt_r  <= $signed(bld_rsp.angle);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign crd_req.start = crd_start_r;
  assign crd_req.x     = x_r;
  assign crd_req.y     = y_r;

  assign bld_req.start  = bld_start_r;
  assign bld_req.angle  = angle_r;
  assign bld_req.filt   = filt_r;
  assign bld_req.gyro   = g_r;
  assign bld_req.dt     = dt_r;
  assign bld_req.weight = weight_r;

  itcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crd_req),
    .rsp   (crd_rsp)
  );

  itcf_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bld_req),
    .rsp   (bld_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_angle_r;
  assign out_tuser  = {out_mode_r, out_ok_r};

  `ITCF_ASSERT_SAME(a_crd_done_in_crd, crd_rsp.done, state_r == ST_CRD)
  `ITCF_ASSERT_SAME(a_bld_done_in_bld, bld_rsp.done, state_r == ST_BLD)
  `ITCF_ASSERT_NEXT(a_accept_starts_cordic, in_acc, crd_start_r && !in_tready)
  `ITCF_ASSERT_SAME(a_load_from_out, $rose(out_valid_r), $past(state_r == ST_OUT))

endmodule

>>> sim/imu_tilt_complementary_filter_top_tb.sv
// self-checking testbench for the tilt-angle complementary filter
module imu_tilt_complementary_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [15:0] angle;
    logic        ok;
    logic        mode;
  } tilt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  imu_tilt_complementary_filter_top #(.CORDIC_STEPS(STEPS)) DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state and register copies
  logic [15:0]  weight_q16;
  logic [15:0]  win_lim [5];
  logic signed [15:0] filt_angle;
  logic [31:0]  last_time;
  logic         disp_mode;

  tilt_result_t pending_results[$];
  int  fail_count = 0;
  int  cycles = 0;
  bit  calm = 1'b0;       // no idling in the final part
  int  time_step_max = 1000;
  logic [31:0] stamp = 0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint accel_tilt_q16(longint ax, longint az);
    longint x, y, z, xs, ys;
    longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
    x = (ax < 0 ? -ax : ax) * 256;
    y = (az < 0 ? -az : az) * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    return z;
  endfunction

  function automatic tilt_result_t predict_tilt(logic [79:0] d, logic [1:0] u);
    tilt_result_t r;
    longint ax, az, g, dt, w, num, mag, q, lo, hi, den;
    logic [31:0] el;
    ax = longint'($signed(d[15:0]));
    az = longint'($signed(d[31:16]));
    g  = longint'($signed(d[47:32]));
    if (u[1]) disp_mode = 1'b1;
    else if (u[0]) disp_mode = 1'b0;
    el = d[79:48] - last_time;
    last_time = d[79:48];
    dt = (el == 0 || el > 1000) ? 10 : longint'(el);
    w = longint'(weight_q16);
    den = 64'd131000 * 64'd16777216;
    num = w * (longint'(filt_angle) * 256 * 131000 + g * dt * 65536)
        + (65536 - w) * accel_tilt_q16(ax, az) * 131000;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    filt_angle = 16'(q);
    lo = longint'($signed(disp_mode ? win_lim[itcf_pkg::REG_DISP_LOW]
                                    : win_lim[itcf_pkg::REG_ASP_LOW]));
    hi = longint'($signed(disp_mode ? win_lim[itcf_pkg::REG_DISP_HIGH]
                                    : win_lim[itcf_pkg::REG_ASP_HIGH]));
    r.angle = filt_angle;
    r.ok = (q >= lo) && (q <= hi);
    r.mode = disp_mode;
    return r;
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
                             logic signed [15:0] gy, logic [31:0] t, logic [1:0] btn);
    idle_gap();
    in_tdata <= {t, gy, az, ax};
    in_tuser <= btn;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_tilt({t, gy, az, ax}, btn));
    // valid is dropped by the next gap or drain, or reused by the next transaction
    @(negedge clk);
  endtask

  task automatic send_random(int span);
    stamp += $urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, span);
    send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), stamp,
                2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {16'h0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx <= itcf_pkg::REG_DISP_HIGH) win_lim[idx] = val;
    if (idx == itcf_pkg::REG_BLEND_WEIGHT) weight_q16 = val;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0, 2'b00);          // zero accel, zero dt
    send_sample(16'sd16384, 16'sd0, 16'sd0, 32'd20, 2'b01);
    send_sample(16'sd0, 16'sd16384, 16'sd131, 32'd40, 2'b10);
    send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 32'd1040, 2'b11); // dt limit
    send_sample(16'sd32767, 16'sd32767, -16'sd32768, 32'd2041, 2'b00);  // over limit
    send_sample(16'sd100, -16'sd3000, 16'sd0, 32'd2041, 2'b01);
    send_sample(16'sd1, 16'sd0, 16'sd0, 32'hffff_fff0, 2'b00);
    send_sample(16'sd0, 16'sd1, 16'sd0, 32'h0000_0005, 2'b10);          // wrapping
    for (int i = 0; i < 8; i++) send_sample(16'sd0, 16'sd0, 16'sd32767, 32'd6 + 1000 * i, 2'b00);
    for (int i = 0; i < 8; i++) send_sample(16'sd0, 16'sd0, -16'sd32768, 32'd8006 + 1000 * i, 2'b00);
  endtask

  task automatic test_registers();
    logic [15:0] wts [4] = '{16'd0, 16'hffff, 16'd32768, 16'd64225};
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(itcf_pkg::REG_BLEND_WEIGHT, wts[p]);
      write_reg(itcf_pkg::REG_ASP_LOW, p == 1 ? 16'h8000 : 16'($urandom()));
      write_reg(itcf_pkg::REG_ASP_HIGH, p == 1 ? 16'h7fff : 16'($urandom()));
      // inverted once
      write_reg(itcf_pkg::REG_DISP_LOW, p == 2 ? 16'h7fff : 16'($urandom_range(0, 8000)));
      write_reg(itcf_pkg::REG_DISP_HIGH,
                p == 2 ? 16'h8000 : 16'($urandom_range(8000, 30000)));
      write_reg(REG_UNMAPPED, 16'($urandom()));  // outside the map, ignored
      for (int i = 0; i < 60; i++) send_random(40);
      drain();
    end
    write_reg(itcf_pkg::REG_ASP_LOW, 16'd21760);
    write_reg(itcf_pkg::REG_ASP_HIGH, 16'd24320);
    write_reg(itcf_pkg::REG_DISP_LOW, 16'd7680);
    write_reg(itcf_pkg::REG_DISP_HIGH, 16'd15360);
  endtask

  task automatic test_random();
    for (int i = 0; i < 600; i++) begin
      send_random(time_step_max);
      if (i == 300) drain();  // sender holds until all results are back
    end
    calm = 1'b1;
    for (int i = 0; i < 60; i++) send_random(30);
  endtask

  // result checker
  always @(posedge clk) begin
    tilt_result_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tilt_angle %0d", $signed(out_tdata));
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata !== exp_r.angle) begin
          $error("tilt_angle expected %0d actual %0d", $signed(exp_r.angle), $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser[0] !== exp_r.ok) begin
          $error("angle_ok expected %0b actual %0b", exp_r.ok, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== exp_r.mode) begin
          $error("current_mode expected %0b actual %0b", exp_r.mode, out_tuser[1]);
          fail_count++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_tilt_complementary_filter_top: mismatch");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 4) != 0) out_tready <= 1'b1;
      else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    weight_q16 = 16'd64225;
    win_lim = '{16'd64225, 16'd21760, 16'd24320, 16'd7680, 16'd15360};
    filt_angle = '0;
    last_time = '0;
    disp_mode = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_random();
    drain();
    if (fail_count == 0 && pending_results.size() == 0)
      $display("imu_tilt_complementary_filter_top: match");
    else
      $display("imu_tilt_complementary_filter_top: mismatch");
    $finish;
  end
endmodule
